// File: hw/rtl/mqps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqps_pkg: shared definitions for the multi-queue periodic server
// Field widths, command and result codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package mqps_pkg;

  localparam int unsigned QID_W   = 3;   // queue_id and queue_id_out
  localparam int unsigned VAL_W   = 16;  // request and served values
  localparam int unsigned PER_W   = 16;  // period registers and countdowns
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CIDX_W  = 3;   // configuration register index

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ENQUEUED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SERVED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a transaction
    S_SCAN,   // one queue's countdown per cycle
    S_SERVE,  // look for the next queue to pop, issue its read
    S_LOAD    // move the popped value into the output register
  } state_t;

endpackage

// File: hw/rtl/multi_queue_periodic_server.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_periodic_server
// Request FIFOs served at fixed per-queue periods, with one shared countdown
// decrementer stepped over the queues by a small sequencer.
// ----------------------------------------------------------------------------
// Enqueue: the result is in the output register in the cycle after the
//   transaction; one enqueue per cycle while the output is taken.
// Tick: the shared decrementer steps through every queue's countdown, then the
//   sequencer walks the queues up to the last one that pops (a single idle
//   result when none does), reading and loading each served request into the
//   output register. The next transaction is taken only once the tick is done.
// Reset (rst, synchronous) sets periods and countdowns to 1 and empties every
//   queue; the request store itself is not cleared.
module multi_queue_periodic_server #(
  parameter int unsigned NUM_QUEUES  = 5,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [mqps_pkg::QID_W-1:0]          queue_id,
  input  logic [mqps_pkg::VAL_W-1:0]          request_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mqps_pkg::KIND_W-1:0]         kind,
  output logic [mqps_pkg::QID_W-1:0]          queue_id_out,
  output logic [mqps_pkg::VAL_W-1:0]          served_value,
  output logic                                all_empty,
  output logic                                last,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mqps_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [mqps_pkg::PER_W-1:0]          cfg_data
);

  localparam int unsigned QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [mqps_pkg::QID_W-1:0] NQ_CODE = mqps_pkg::QID_W'(NUM_QUEUES);
  localparam logic [CW-1:0]  FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]  LAST_PTR   = PW'(QUEUE_DEPTH - 1);
  localparam logic [QIW-1:0] LAST_Q     = QIW'(NUM_QUEUES - 1);

  // Registers
  mqps_pkg::state_t               state, state_next;
  logic [mqps_pkg::PER_W-1:0]     period    [NUM_QUEUES];
  logic [mqps_pkg::PER_W-1:0]     countdown [NUM_QUEUES];
  logic [PW-1:0]                  head      [NUM_QUEUES];
  logic [PW-1:0]                  tail      [NUM_QUEUES];
  logic [CW-1:0]                  fill      [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]          pop_mask;
  logic [QIW-1:0]                 idx;
  logic [mqps_pkg::VAL_W-1:0]     rd_data;
  logic [mqps_pkg::VAL_W-1:0]     store [NUM_QUEUES][QUEUE_DEPTH];

  // Combinational control
  logic                           out_free;
  logic                           in_acc;
  logic                           cfg_acc;
  logic [QIW-1:0]                 qid_idx;
  logic [QIW-1:0]                 sel_q;
  logic [CW-1:0]                  fill_sel;
  logic [mqps_pkg::PER_W-1:0]     cd_dec;
  logic                           in_range;
  logic                           enq_ok;
  logic                           all_zero;
  logic [NUM_QUEUES-1:0]          mask_rest;
  logic                           do_enqueue;
  logic                           do_scan;
  logic                           do_read;
  logic                           do_skip;
  logic                           do_emit;
  logic                           load_out;
  logic [mqps_pkg::KIND_W-1:0]    kind_next;
  logic [mqps_pkg::QID_W-1:0]     qid_out_next;
  logic [mqps_pkg::VAL_W-1:0]     value_next;
  logic                           empty_next;
  logic                           last_next;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == mqps_pkg::S_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state == mqps_pkg::S_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign qid_idx   = queue_id[QIW-1:0];
  // The fill count for enqueue and pop decisions is read at one place: the
  // enqueue target while idle, the sequencer's queue otherwise.
  assign sel_q     = (state == mqps_pkg::S_IDLE) ? qid_idx : idx;
  assign fill_sel  = fill[sel_q];
  assign cd_dec    = countdown[idx] - mqps_pkg::PER_W'(1);
  assign in_range  = (queue_id < NQ_CODE);
  assign enq_ok    = in_range && (fill_sel != FULL_COUNT);
  assign mask_rest = pop_mask & ~(NUM_QUEUES'(1) << idx);

  always_comb begin
    all_zero = 1'b1;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (fill[q] != '0) begin
        all_zero = 1'b0;
      end
    end
  end

  // Next state and output-register loading
  always_comb begin
    state_next   = state;
    do_enqueue   = 1'b0;
    do_scan      = 1'b0;
    do_read      = 1'b0;
    do_skip      = 1'b0;
    do_emit      = 1'b0;
    load_out     = 1'b0;
    kind_next    = mqps_pkg::KIND_IDLE;
    qid_out_next = '0;
    value_next   = '0;
    empty_next   = all_zero;
    last_next    = 1'b1;
    case (state)
      mqps_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd == mqps_pkg::CMD_TICK) begin
            state_next = mqps_pkg::S_SCAN;
          end else begin
            do_enqueue   = enq_ok;
            load_out     = 1'b1;
            kind_next    = enq_ok ? mqps_pkg::KIND_ENQUEUED : mqps_pkg::KIND_DROPPED;
            qid_out_next = queue_id;
            empty_next   = enq_ok ? 1'b0 : all_zero;
          end
        end
      end
      mqps_pkg::S_SCAN: begin
        do_scan = 1'b1;
        if (idx == LAST_Q) begin
          state_next = mqps_pkg::S_SERVE;
        end
      end
      mqps_pkg::S_SERVE: begin
        if (pop_mask == '0) begin
          // No queue popped on this tick: a single idle result.
          if (out_free) begin
            load_out   = 1'b1;
            state_next = mqps_pkg::S_IDLE;
          end
        end else if (pop_mask[idx]) begin
          do_read    = 1'b1;
          state_next = mqps_pkg::S_LOAD;
        end else begin
          do_skip = 1'b1;
        end
      end
      mqps_pkg::S_LOAD: begin
        if (out_free) begin
          do_emit      = 1'b1;
          load_out     = 1'b1;
          kind_next    = mqps_pkg::KIND_SERVED;
          qid_out_next = mqps_pkg::QID_W'(idx);
          value_next   = rd_data;
          last_next    = (mask_rest == '0);
          state_next   = (mask_rest == '0) ? mqps_pkg::S_IDLE : mqps_pkg::S_SERVE;
        end
      end
      default: begin
        state_next = mqps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Queue bookkeeping and the sequencer's index
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        period[q]    <= mqps_pkg::PER_W'(1);
        countdown[q] <= mqps_pkg::PER_W'(1);
        head[q]      <= '0;
        tail[q]      <= '0;
        fill[q]      <= '0;
      end
      pop_mask <= '0;
      idx      <= '0;
    end else begin
      if (cfg_acc && (cfg_index < NQ_CODE)) begin
        period[cfg_index[QIW-1:0]]    <= cfg_data;
        countdown[cfg_index[QIW-1:0]] <= cfg_data;
      end
      if (in_acc && (cmd == mqps_pkg::CMD_TICK)) begin
        idx      <= '0;
        pop_mask <= '0;
      end
      if (do_enqueue) begin
        fill[qid_idx] <= fill_sel + CW'(1);
        tail[qid_idx] <= (tail[qid_idx] == LAST_PTR) ? '0 : tail[qid_idx] + PW'(1);
      end
      if (do_scan) begin
        if (cd_dec == '0) begin
          countdown[idx] <= period[idx];
          if (fill_sel != '0) begin
            fill[idx]     <= fill_sel - CW'(1);
            pop_mask[idx] <= 1'b1;
          end
        end else begin
          countdown[idx] <= cd_dec;
        end
        idx <= (idx == LAST_Q) ? '0 : idx + QIW'(1);
      end
      if (do_read) begin
        head[idx] <= (head[idx] == LAST_PTR) ? '0 : head[idx] + PW'(1);
      end
      if (do_skip) begin
        idx <= idx + QIW'(1);
      end
      if (do_emit) begin
        pop_mask <= mask_rest;
        idx      <= (mask_rest == '0) ? '0 : idx + QIW'(1);
      end
    end
  end

  // Request store: one write port for enqueues, one registered read port
  always_ff @(posedge clk) begin
    if (do_enqueue) begin
      store[qid_idx][tail[qid_idx]] <= request_value;
    end
    if (do_read) begin
      rd_data <= store[idx][head[idx]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind         <= kind_next;
      queue_id_out <= qid_out_next;
      served_value <= value_next;
      all_empty    <= empty_next;
      last         <= last_next;
    end
  end

endmodule
